// File: rtl/core/hch_pkg.sv
// shared types and constants of the hog cell orientation histogram
// used by hch_ctrl, hch_datapath and hog_cell_histogram
`timescale 1ns / 1ps
`default_nettype none

package hch_pkg;

    // histogram shape
    localparam int NUM_BINS = 9;
    localparam int BIN_W    = 4;
    localparam int SUM_W    = 24;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // special orientation bins
    localparam logic [BIN_W-1:0] BIN_HORIZONTAL = 4'd0;
    localparam logic [BIN_W-1:0] BIN_VERTICAL   = 4'd4;
    localparam logic [BIN_W-1:0] BIN_MIRROR     = 4'd8;
    localparam logic [BIN_W-1:0] BIN_LAST       = 4'(NUM_BINS - 1);

    // magnitude: floor(sqrt(256 * (fx^2 + fy^2))), 13 result bits
    localparam int MAG_W      = 13;
    localparam int RAD_W      = 2 * MAG_W;
    localparam int ROOT_STEPS = MAG_W;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    // tan(20k degrees) scaled by 1e9, k = 1..4
    localparam int NUM_BOUNDS = 4;
    localparam int TAN_W      = 33;
    localparam int CMP_W      = 41;
    localparam logic [29:0] TAN_SCALE = 30'd1000000000;
    localparam logic [TAN_W-1:0] TAN_BOUND [NUM_BOUNDS] = '{
        33'd363970234,
        33'd839099631,
        33'd1732050807,
        33'd5671281819
    };

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_ACCUM,
        S_OUTPUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic square;
        logic root;
        logic accum;
        logic emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last_pixel;
        logic out_last;
    } t_status;

endpackage

`default_nettype wire

// File: rtl/core/hog_cell_histogram.sv
// HOG cell histogram: nine 20-degree unsigned orientation bins.
// Input channel (i_in_valid / o_in_ready) takes one item per cell pixel:
// its four neighbours and a last-pixel mark. Central differences fx, fy
// give magnitude floor(16*sqrt(fx^2+fy^2)), added with saturation at
// 2^24-1 into the bin of the gradient's orientation.
// Output channel (o_out_valid / i_out_ready) gives nine items, bins 0..8,
// after the last pixel of a cell; o_last_bin marks bin 8. Each sum is
// cleared as its item is taken.
// Sequence: each pixel item passes through accept, a squaring step, a
// one-bit-per-cycle square root (the four orientation compares share its
// first steps) and an accumulate step; the next item is taken only after.
// After the last pixel the nine results follow at one per cycle while
// i_out_ready is high; a stalled receiver holds the current result and
// no new pixel is taken until bin 8 is delivered.
// Reset (synchronous, active low) clears all sums and returns to idle.
// Depends on hch_pkg, hch_ctrl and hch_datapath.
`timescale 1ns / 1ps
`default_nettype none

module hog_cell_histogram (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire  [7:0]                  i_left_pixel,
    input  wire  [7:0]                  i_right_pixel,
    input  wire  [7:0]                  i_up_pixel,
    input  wire  [7:0]                  i_down_pixel,
    input  wire                         i_last_pixel,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output logic [hch_pkg::BIN_W-1:0]   o_bin_index,
    output logic [hch_pkg::SUM_W-1:0]   o_bin_sum,
    output logic                        o_last_bin
);
    import hch_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // sequencer
    hch_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // arithmetic and accumulators
    hch_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_left_pixel  (i_left_pixel),
        .i_right_pixel (i_right_pixel),
        .i_up_pixel    (i_up_pixel),
        .i_down_pixel  (i_down_pixel),
        .i_last_pixel  (i_last_pixel),
        .o_bin_index   (o_bin_index),
        .o_bin_sum     (o_bin_sum),
        .o_last_bin    (o_last_bin)
    );

endmodule

`default_nettype wire

// File: rtl/core/hch_ctrl.sv
// sequencer of the hog cell histogram: load, square, root, accumulate, emit
// depends on hch_pkg
`timescale 1ns / 1ps
`default_nettype none

module hch_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  hch_pkg::t_status  i_status,
    output hch_pkg::t_cmd     o_cmd
);
    import hch_pkg::*;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                w_root_done;

    assign w_root_done = (r_step == STEP_W'(ROOT_STEPS - 1));

    // state and step counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // step counter for the square root iterations
    always_comb begin
        n_step = r_step;
        if (r_state == S_SQUARE) begin
            n_step = '0;
        end else if (r_state == S_ROOT && !w_root_done) begin
            n_step = r_step + 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SQUARE;
            end
            S_SQUARE: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (w_root_done) n_state = S_ACCUM;
            end
            S_ACCUM: begin
                n_state = i_status.last_pixel ? S_OUTPUT : S_IDLE;
            end
            S_OUTPUT: begin
                if (i_out_ready && i_status.out_last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs and commands
    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_out_valid  = (r_state == S_OUTPUT);
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.square = (r_state == S_SQUARE);
        o_cmd.root   = (r_state == S_ROOT);
        o_cmd.accum  = (r_state == S_ACCUM);
        o_cmd.emit   = (r_state == S_OUTPUT) && i_out_ready;
    end

endmodule

`default_nettype wire

// File: rtl/core/hch_datapath.sv
// datapath of the hog cell histogram: gradients, serial square root,
// orientation compare, bin accumulators and output index
// depends on hch_pkg
`timescale 1ns / 1ps
`default_nettype none

module hch_datapath (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  hch_pkg::t_cmd                i_cmd,
    output hch_pkg::t_status             o_status,
    input  wire  [7:0]                   i_left_pixel,
    input  wire  [7:0]                   i_right_pixel,
    input  wire  [7:0]                   i_up_pixel,
    input  wire  [7:0]                   i_down_pixel,
    input  wire                          i_last_pixel,
    output logic [hch_pkg::BIN_W-1:0]    o_bin_index,
    output logic [hch_pkg::SUM_W-1:0]    o_bin_sum,
    output logic                         o_last_bin
);
    import hch_pkg::*;

    logic signed [8:0]      r_fx, r_fy;
    logic                   r_last;
    logic [7:0]             r_ax, r_ay;
    logic [RAD_W-1:0]       r_rad;
    logic [MAG_W+2:0]       r_rem;
    logic [MAG_W-1:0]       r_root;
    logic [2:0]             r_k;
    logic [2:0]             r_count;
    logic [BIN_W-1:0]       r_out_idx;
    logic [SUM_W-1:0]       r_acc [NUM_BINS];

    logic [16:0]            w_sq;
    logic [MAG_W+4:0]       w_rem_sh, w_trial;
    logic [CMP_W-1:0]       w_lhs, w_rhs;
    logic [BIN_W-1:0]       w_bin, w_addr;
    logic [SUM_W-1:0]       w_rd;
    logic [SUM_W:0]         w_sum;
    logic [SUM_W-1:0]       w_new;

    // sum of squared differences
    assign w_sq = 17'(r_fx * r_fx) + 17'(r_fy * r_fy);

    // one radicand digit pair per root step
    assign w_rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial  = (MAG_W+5)'({r_root, 2'b01});

    // one orientation boundary per step: |fy| * scale > |fx| * tan bound
    assign w_lhs = CMP_W'(r_ay) * CMP_W'(TAN_SCALE);
    assign w_rhs = CMP_W'(r_ax) * CMP_W'(TAN_BOUND[r_k[1:0]]);

    // bin selection from the boundary count and the quadrant
    always_comb begin
        if (r_fx == 9'sd0) begin
            w_bin = BIN_VERTICAL;
        end else if (r_fy == 9'sd0) begin
            w_bin = BIN_HORIZONTAL;
        end else if (r_fx[8] == r_fy[8]) begin
            w_bin = BIN_W'(r_count);
        end else begin
            w_bin = BIN_MIRROR - BIN_W'(r_count);
        end
    end

    // single accumulator read port
    assign w_addr = i_cmd.accum ? w_bin : r_out_idx;
    assign w_rd   = r_acc[w_addr];

    // saturating accumulate
    assign w_sum = (SUM_W+1)'(w_rd) + (SUM_W+1)'(r_root);
    assign w_new = w_sum[SUM_W] ? SUM_MAX : w_sum[SUM_W-1:0];

    // gradient, magnitude and orientation registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fx   <= $signed({1'b0, i_right_pixel}) - $signed({1'b0, i_left_pixel});
            r_fy   <= $signed({1'b0, i_down_pixel}) - $signed({1'b0, i_up_pixel});
            r_last <= i_last_pixel;
        end
        if (i_cmd.square) begin
            r_ax    <= 8'(r_fx[8] ? -r_fx : r_fx);
            r_ay    <= 8'(r_fy[8] ? -r_fy : r_fy);
            r_rad   <= RAD_W'({w_sq, 8'd0});
            r_rem   <= '0;
            r_root  <= '0;
            r_k     <= '0;
            r_count <= '0;
        end
        if (i_cmd.root) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                r_rem  <= (MAG_W+3)'(w_rem_sh - w_trial);
                r_root <= {r_root[MAG_W-2:0], 1'b1};
            end else begin
                r_rem  <= (MAG_W+3)'(w_rem_sh);
                r_root <= {r_root[MAG_W-2:0], 1'b0};
            end
            if (r_k < 3'(NUM_BOUNDS)) begin
                r_k <= r_k + 1'b1;
                if (w_lhs > w_rhs) r_count <= r_count + 1'b1;
            end
        end
    end

    // accumulators and output index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BINS; i++) r_acc[i] <= '0;
            r_out_idx <= '0;
        end else begin
            if (i_cmd.accum) begin
                r_acc[w_addr] <= w_new;
            end
            if (i_cmd.emit) begin
                r_acc[r_out_idx] <= '0;
                r_out_idx <= (r_out_idx == BIN_LAST) ? '0 : r_out_idx + 1'b1;
            end
        end
    end

    assign o_status.last_pixel = r_last;
    assign o_status.out_last   = (r_out_idx == BIN_LAST);
    assign o_bin_index         = r_out_idx;
    assign o_bin_sum           = w_rd;
    assign o_last_bin          = (r_out_idx == BIN_LAST);

endmodule

`default_nettype wire

// File: tb/hog_cell_histogram_tb.sv
// testbench for hog_cell_histogram: gradient binning, cell output, stalls
// depends on hch_pkg and the hog_cell_histogram rtl; self-checking, no files read
`timescale 1ns / 1ps

module hog_cell_histogram_tb;

    localparam int  CYCLE_LIMIT   = 400000;
    localparam int  SETTLE_CYCLES = 40;
    localparam int  RANDOM_ITEMS  = 146;
    localparam int  IDLE_PCT      = 28;
    localparam longint unsigned TAN_E15_SCALE = 64'd1000000000000000;

    // one histogram entry as the block delivers it
    typedef struct {
        logic [hch_pkg::BIN_W-1:0] bin_idx;
        logic [hch_pkg::SUM_W-1:0] sum;
        logic                      last;
    } t_hist_entry;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_ready;
    logic [7:0]                  i_left_pixel = 8'd0;
    logic [7:0]                  i_right_pixel = 8'd0;
    logic [7:0]                  i_up_pixel = 8'd0;
    logic [7:0]                  i_down_pixel = 8'd0;
    logic                        i_last_pixel = 1'b0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic [hch_pkg::BIN_W-1:0]   o_bin_index;
    logic [hch_pkg::SUM_W-1:0]   o_bin_sum;
    logic                        o_last_bin;

    logic [hch_pkg::SUM_W-1:0]   hist_sums [hch_pkg::NUM_BINS] = '{default: '0};
    t_hist_entry                 expected_bins [$];
    t_hist_entry                 next_entry;
    int                          fail_count = 0;
    int                          cycle_count = 0;
    logic                        steady_flow = 1'b0;

    hog_cell_histogram u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_left_pixel  (i_left_pixel),
        .i_right_pixel (i_right_pixel),
        .i_up_pixel    (i_up_pixel),
        .i_down_pixel  (i_down_pixel),
        .i_last_pixel  (i_last_pixel),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_bin_index   (o_bin_index),
        .o_bin_sum     (o_bin_sum),
        .o_last_bin    (o_last_bin)
    );

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // tan of 20, 40, 60 and 80 degrees, scaled by 1e15
    function automatic longint unsigned tan_limit(int k);
        case (k)
            0:       return 64'd363970234266202;
            1:       return 64'd839099631177280;
            2:       return 64'd1732050807568877;
            default: return 64'd5671281819617710;
        endcase
    endfunction

    // floor(16 * sqrt(fx^2 + fy^2)), built one result bit at a time
    function automatic int unsigned gradient_magnitude(int fx, int fy);
        int unsigned radicand;
        int unsigned root;
        int unsigned trial;
        radicand = 256 * (fx * fx + fy * fy);
        root = 0;
        for (int b = hch_pkg::MAG_W - 1; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root;
    endfunction

    // unsigned orientation bin, 20 degrees wide
    function automatic logic [hch_pkg::BIN_W-1:0] orientation_bin(int fx, int fy);
        longint unsigned ax;
        longint unsigned ay;
        int steps;
        if (fx == 0)
            return hch_pkg::BIN_VERTICAL;
        if (fy == 0)
            return hch_pkg::BIN_HORIZONTAL;
        ax = 64'((fx < 0) ? -fx : fx);
        ay = 64'((fy < 0) ? -fy : fy);
        steps = 0;
        // count the 20/40/60/80 degree boundaries below the angle
        for (int k = 0; k < 4; k++) begin
            if (ay * TAN_E15_SCALE > ax * tan_limit(k))
                steps++;
        end
        if ((fx > 0) == (fy > 0))
            return hch_pkg::BIN_W'(steps);
        return hch_pkg::BIN_MIRROR - hch_pkg::BIN_W'(steps);
    endfunction

    // add one pixel into the histogram; on the last pixel queue the nine sums
    function automatic void accumulate_pixel(logic [7:0] l, logic [7:0] r, logic [7:0] u,
                                             logic [7:0] d, logic last);
        int fx;
        int fy;
        logic [hch_pkg::BIN_W-1:0] b;
        logic [hch_pkg::SUM_W:0]   total;
        t_hist_entry               e;
        fx = int'(r) - int'(l);
        fy = int'(d) - int'(u);
        b = orientation_bin(fx, fy);
        total = (hch_pkg::SUM_W+1)'(hist_sums[b])
              + (hch_pkg::SUM_W+1)'(gradient_magnitude(fx, fy));
        hist_sums[b] = (total > hch_pkg::SUM_MAX) ? hch_pkg::SUM_MAX
                                                   : total[hch_pkg::SUM_W-1:0];
        if (last) begin
            for (int k = 0; k < hch_pkg::NUM_BINS; k++) begin
                e.bin_idx = hch_pkg::BIN_W'(k);
                e.sum = hist_sums[k];
                e.last = (k == hch_pkg::NUM_BINS - 1);
                expected_bins.insert(expected_bins.size(), e);
                hist_sums[k] = '0;
            end
        end
    endfunction

    // send one pixel item, with a random gap in front unless flow is steady
    task automatic send_pixel(input logic [7:0] l, input logic [7:0] r, input logic [7:0] u,
                              input logic [7:0] d, input logic last);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_left_pixel  <= l;
        i_right_pixel <= r;
        i_up_pixel    <= u;
        i_down_pixel  <= d;
        i_last_pixel  <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        accumulate_pixel(l, r, u, d, last);
    endtask

    // hold off the sender until every queued sum has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_bins.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // zero differences, axis directions, all quadrants, bin boundaries
    task automatic test_directed_gradients();
        send_pixel(8'd128, 8'd128, 8'd77,  8'd77,  1'b0);
        send_pixel(8'd0,   8'd0,   8'd0,   8'd255, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd255, 8'd9,   8'd9,   1'b0);
        send_pixel(8'd255, 8'd0,   8'd200, 8'd200, 1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   8'd255, 1'b1);
        // diagonals in the remaining quadrants, steep and shallow extremes
        send_pixel(8'd255, 8'd0,   8'd0,   8'd255, 1'b0);
        send_pixel(8'd0,   8'd255, 8'd255, 8'd0,   1'b0);
        send_pixel(8'd255, 8'd0,   8'd255, 8'd0,   1'b0);
        send_pixel(8'd0,   8'd1,   8'd0,   8'd255, 1'b0);
        send_pixel(8'd1,   8'd0,   8'd0,   8'd255, 1'b0);
        send_pixel(8'd0,   8'd255, 8'd0,   8'd1,   1'b0);
        send_pixel(8'd255, 8'd0,   8'd0,   8'd1,   1'b1);
        // just above and just below each boundary
        send_pixel(8'd0,   8'd200, 8'd0,   8'd73,  1'b0);
        send_pixel(8'd0,   8'd200, 8'd0,   8'd72,  1'b0);
        send_pixel(8'd0,   8'd100, 8'd0,   8'd84,  1'b0);
        send_pixel(8'd0,   8'd100, 8'd0,   8'd83,  1'b0);
        send_pixel(8'd0,   8'd100, 8'd0,   8'd174, 1'b0);
        send_pixel(8'd0,   8'd100, 8'd0,   8'd173, 1'b0);
        send_pixel(8'd0,   8'd45,  8'd0,   8'd255, 1'b0);
        send_pixel(8'd0,   8'd44,  8'd0,   8'd250, 1'b0);
        send_pixel(8'd100, 8'd0,   8'd0,   8'd174, 1'b1);
        // single-pixel cells: flat and saturated neighbours
        send_pixel(8'd3,   8'd3,   8'd3,   8'd3,   1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
        wait_for_results();
    endtask

    // random cells of random length with random neighbours
    task automatic test_random_cells();
        int sent;
        int cell_len;
        int mode;
        logic [7:0] l, r, u, d;
        logic last;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            cell_len = $urandom_range(1, 12);
            for (int k = 0; k < cell_len; k++) begin
                // a long run without any idling in the middle
                steady_flow <= (sent >= 60 && sent < 120);
                mode = $urandom_range(9);
                l = 8'($urandom_range(255));
                r = 8'($urandom_range(255));
                u = 8'($urandom_range(255));
                d = 8'($urandom_range(255));
                if (mode == 0)
                    r = l;
                else if (mode == 1)
                    d = u;
                last = (k == cell_len - 1) || ($urandom_range(99) < 4);
                send_pixel(l, r, u, d, last);
                sent++;
            end
        end
        steady_flow <= 1'b0;
        wait_for_results();
    endtask

    // receiver stalls at random unless flow is steady
    always @(posedge i_clk) begin
        i_out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare each delivered bin with the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bins.size() == 0) begin
                $display("%0t: unexpected item bin %0d sum %0d last %0b",
                         $time, o_bin_index, o_bin_sum, o_last_bin);
                fail_count++;
            end else begin
                next_entry = expected_bins.pop_front();
                if (o_bin_index !== next_entry.bin_idx) begin
                    $display("%0t: bin_index expected %0d actual %0d",
                             $time, next_entry.bin_idx, o_bin_index);
                    fail_count++;
                end
                if (o_bin_sum !== next_entry.sum) begin
                    $display("%0t: bin_sum (bin %0d) expected %0d actual %0d",
                             $time, next_entry.bin_idx, next_entry.sum, o_bin_sum);
                    fail_count++;
                end
                if (o_last_bin !== next_entry.last) begin
                    $display("%0t: last_bin (bin %0d) expected %0b actual %0b",
                             $time, next_entry.bin_idx, next_entry.last, o_last_bin);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // test sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_gradients();
        test_random_cells();
        if (fail_count == 0 && expected_bins.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
